/* design/sclpwm_pkg.sv */
package sclpwm_pkg;

  localparam int BYTE_W     = 8;
  localparam int DUTY_W     = 12;
  localparam int SPAN_W     = DUTY_W + 1;
  localparam int SPEED_W    = 7;
  localparam int MAG_W      = SPEED_W + DUTY_W;
  localparam int CFG_IDX_W  = 1;
  localparam int RESULTS    = 4;
  localparam int CNT_W      = 3;
  localparam int PTR_W      = 2;

  // floor(m / 100) == (m * RECIP) >> RECIP_SHIFT for every m below 2**MAG_W
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP = 20'd671089;

  localparam logic [DUTY_W-1:0] DUTY_LOW_RST  = 12'd532;
  localparam logic [DUTY_W-1:0] DUTY_HIGH_RST = 12'd983;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH = 1'b1;

  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_P       = 8'h70;
  localparam logic [BYTE_W-1:0] CH_S       = 8'h73;

  localparam logic KIND_DUTY = 1'b0;
  localparam logic KIND_CAL  = 1'b1;
  localparam logic WHEEL_RIGHT = 1'b0;
  localparam logic WHEEL_LEFT  = 1'b1;

  typedef enum logic [1:0] {
    SPD_NONE,
    SPD_ZERO,
    SPD_POS
  } speed_class_e;

  typedef struct packed {
    speed_class_e       cls;
    logic [SPEED_W-1:0] mag;
  } speed_t;

  // one decoded command line, products already formed
  typedef struct packed {
    logic             cal;
    speed_class_e     cls_r;
    speed_class_e     cls_l;
    logic             span_neg;
    logic [MAG_W-1:0] mag_r;
    logic [MAG_W-1:0] mag_l;
  } job_t;

  typedef struct packed {
    logic              kind;
    logic              wheel;
    logic [DUTY_W-1:0] duty;
  } result_t;

endpackage

/* design/sclpwm_pair_decode.sv */
module sclpwm_pair_decode
  import sclpwm_pkg::*;
(
  input  logic [BYTE_W-1:0] a_i,
  input  logic [BYTE_W-1:0] b_i,
  output speed_t            speed_o
);

  logic             a_blank;
  logic             a_digit;
  logic             b_digit;
  logic [3:0]       da;
  logic [3:0]       db;
  logic [SPEED_W-1:0] val;
  logic             neg;

  assign a_blank = (a_i == CH_SPACE) || ((a_i >= CH_TAB) && (a_i <= CH_CR));
  assign a_digit = (a_i >= CH_ZERO) && (a_i <= CH_NINE);
  assign b_digit = (b_i >= CH_ZERO) && (b_i <= CH_NINE);
  assign da = a_i[3:0];
  assign db = b_i[3:0];

  always_comb begin
    val = '0;
    neg = 1'b0;
    if (a_blank) begin
      if (b_digit) begin
        val = SPEED_W'(db);
      end
    end else if ((a_i == CH_MINUS) || (a_i == CH_PLUS)) begin
      if (b_digit) begin
        val = SPEED_W'(db);
        neg = (a_i == CH_MINUS);
      end
    end else if (a_digit) begin
      if (b_digit) begin
        val = SPEED_W'({da, 3'b000}) + SPEED_W'({da, 1'b0}) + SPEED_W'(db);
      end else begin
        val = SPEED_W'(da);
      end
    end
  end

  // "-0" reads as zero
  always_comb begin
    speed_o.mag = val;
    if (val == '0) begin
      speed_o.cls = SPD_ZERO;
    end else if (neg) begin
      speed_o.cls = SPD_NONE;
    end else begin
      speed_o.cls = SPD_POS;
    end
  end

endmodule

/* design/sclpwm_result_stage.sv */
module sclpwm_result_stage
  import sclpwm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  input  logic [DUTY_W-1:0] duty_low_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic              out_wheel_o,
  output logic [DUTY_W-1:0] out_duty_o,
  output logic              out_last_o
);

  localparam int PROD_W = MAG_W + RECIP_W;

  result_t          slot_q [RESULTS];
  result_t          slot_d [RESULTS];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic             valid_q, valid_d;

  logic [PROD_W-1:0] prod_r, prod_l;
  logic [DUTY_W-1:0] quo_r, quo_l;
  logic [DUTY_W-1:0] duty_r, duty_l;
  logic [PTR_W-1:0]  nr;
  logic              is_last;
  logic              beat;
  logic              load;

  // divide by 100 through the reciprocal
  assign prod_r = PROD_W'(job_i.mag_r) * PROD_W'(RECIP);
  assign prod_l = PROD_W'(job_i.mag_l) * PROD_W'(RECIP);
  assign quo_r  = prod_r[RECIP_SHIFT +: DUTY_W];
  assign quo_l  = prod_l[RECIP_SHIFT +: DUTY_W];
  assign duty_r = job_i.span_neg ? (duty_low_i - quo_r) : (duty_low_i + quo_r);
  assign duty_l = job_i.span_neg ? (duty_low_i - quo_l) : (duty_low_i + quo_l);

  assign is_last = ((CNT_W'(ptr_q) + CNT_W'(1)) == cnt_q);
  assign beat    = valid_q && out_ready_i;
  assign take_o  = !valid_q || (out_ready_i && is_last);
  assign load    = job_valid_i && take_o;

  // build the ordered result list: right wheel first, then left
  always_comb begin
    for (int i = 0; i < RESULTS; i++) begin
      slot_d[i] = '0;
    end
    nr    = '0;
    cnt_d = '0;
    if (job_i.cal) begin
      slot_d[0].kind = KIND_CAL;
      cnt_d = CNT_W'(1);
    end else begin
      case (job_i.cls_r)
        SPD_ZERO: begin
          slot_d[1].wheel = WHEEL_LEFT;
          nr = PTR_W'(2);
        end
        SPD_POS: begin
          slot_d[0].duty = duty_r;
          nr = PTR_W'(1);
        end
        default: nr = '0;
      endcase
      cnt_d = CNT_W'(nr);
      case (job_i.cls_l)
        SPD_ZERO: begin
          slot_d[nr + PTR_W'(1)].wheel = WHEEL_LEFT;
          cnt_d = CNT_W'(nr) + CNT_W'(2);
        end
        SPD_POS: begin
          slot_d[nr].wheel = WHEEL_LEFT;
          slot_d[nr].duty  = duty_l;
          cnt_d = CNT_W'(nr) + CNT_W'(1);
        end
        default: cnt_d = CNT_W'(nr);
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (load) begin
      valid_d = 1'b1;
      ptr_d   = '0;
    end else if (beat && is_last) begin
      valid_d = 1'b0;
    end else if (beat) begin
      ptr_d = ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
      if (load) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < RESULTS; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = slot_q[ptr_q].kind;
  assign out_wheel_o = slot_q[ptr_q].wheel;
  assign out_duty_o  = slot_q[ptr_q].duty;
  assign out_last_o  = is_last;

endmodule

/* design/speed_command_line_to_pwm.sv */
// Speed command line to PWM duty writer. Received serial bytes go into a line
// buffer of LINE_BYTES bytes (the write index sticks at the last slot); a
// newline ends the line and sends out one result beat per write: a calibrate
// request when byte 0 is 's' and byte 4 is 'p', otherwise duty writes for the
// right wheel (bytes 0-1) and then the left wheel (bytes 3-4), each read as a
// two-character signed decimal. Speeds 1..99 give
// duty_low + speed*(duty_high-duty_low)/100, zero gives a zero write to both
// wheels, a negative speed gives nothing; out_last_o marks the final beat of
// a line. Timing: a byte can be taken every cycle. A newline is decoded and
// multiplied into the job register at its accept edge, moves into the result
// list when the result register is free, and its beats leave one per cycle
// while out_ready_i is high, so the first beat shows after both registers are
// loaded. A line with n results (n up to 4) holds the result register until
// its last beat is taken; a newline that finds the job register still held
// waits with in_ready_o low until the list ahead of it drains. Duty registers
// are written through the plain write port (index 0 duty_low, 1 duty_high).
module speed_command_line_to_pwm
  import sclpwm_pkg::*;
#(
  parameter int LINE_BYTES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BYTE_W-1:0]    in_rx_byte_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_kind_o,
  output logic                 out_wheel_o,
  output logic [DUTY_W-1:0]    out_duty_o,
  output logic                 out_last_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DUTY_W-1:0]    cfg_wdata_i
);

  localparam int IDX_W = $clog2(LINE_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_BYTES - 1);

  // line buffer slots that the decoder looks at
  localparam logic [IDX_W-1:0] POS_R_HI = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_R_LO = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_L_HI = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_L_LO = IDX_W'(4);

  logic [DUTY_W-1:0] duty_low_q, duty_high_q;
  logic [BYTE_W-1:0] store_q [LINE_BYTES];
  logic [IDX_W-1:0]  widx_q, widx_d;

  logic              job_valid_q, job_valid_d;
  job_t              job_q, job_d;
  logic              take;
  logic              job_move;

  logic              in_beat;
  logic              is_nl;
  logic [BYTE_W-1:0] b0, b1, b3, b4;
  speed_t            spd_r, spd_l;
  logic              cal;
  logic [CNT_W-1:0]  n_r, n_l, n_all;
  logic [SPAN_W-1:0] span;
  logic [DUTY_W-1:0] span_abs;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_low_q  <= DUTY_LOW_RST;
      duty_high_q <= DUTY_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DUTY_LOW:  duty_low_q  <= cfg_wdata_i;
        REG_DUTY_HIGH: duty_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // byte intake and line buffer
  // ---------------------------------------------------------------------
  // the job register frees in the same cycle the result stage takes it;
  // only a newline needs it, other bytes go straight into the buffer
  assign job_move   = job_valid_q && take;
  assign in_ready_o = !is_nl || !job_valid_q || take;
  assign in_beat    = in_valid_i && in_ready_o;
  assign is_nl      = (in_rx_byte_i == CH_NEWLINE);

  always_comb begin
    widx_d = widx_q;
    if (in_beat) begin
      if (is_nl) begin
        widx_d = '0;
      end else if (widx_q != LAST_IDX) begin
        widx_d = widx_q + IDX_W'(1);
      end
    end
  end

  // a newline leaves the buffer filled with ascii zero; the terminator is only
  // patched in at the write index, for the decode of this same line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      for (int i = 0; i < LINE_BYTES; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      widx_q <= widx_d;
      if (in_beat) begin
        if (is_nl) begin
          for (int i = 0; i < LINE_BYTES; i++) begin
            store_q[i] <= CH_ZERO;
          end
        end else begin
          store_q[widx_q] <= in_rx_byte_i;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // line decode, with the terminator patched in at the write index
  // ---------------------------------------------------------------------
  assign b0 = (widx_q == POS_R_HI) ? '0 : store_q[POS_R_HI];
  assign b1 = (widx_q == POS_R_LO) ? '0 : store_q[POS_R_LO];
  assign b3 = (widx_q == POS_L_HI) ? '0 : store_q[POS_L_HI];
  assign b4 = (widx_q == POS_L_LO) ? '0 : store_q[POS_L_LO];

  assign cal = (b0 == CH_S) && (b4 == CH_P);

  sclpwm_pair_decode u_dec_r (
    .a_i     (b0),
    .b_i     (b1),
    .speed_o (spd_r)
  );

  sclpwm_pair_decode u_dec_l (
    .a_i     (b3),
    .b_i     (b4),
    .speed_o (spd_l)
  );

  // beats per wheel: zero speed writes both wheels
  always_comb begin
    case (spd_r.cls)
      SPD_ZERO: n_r = CNT_W'(2);
      SPD_POS:  n_r = CNT_W'(1);
      default:  n_r = '0;
    endcase
    case (spd_l.cls)
      SPD_ZERO: n_l = CNT_W'(2);
      SPD_POS:  n_l = CNT_W'(1);
      default:  n_l = '0;
    endcase
    n_all = cal ? CNT_W'(1) : (n_r + n_l);
  end

  // span sign kept apart so the product stays unsigned
  assign span     = {1'b0, duty_high_q} - {1'b0, duty_low_q};
  assign span_abs = span[SPAN_W-1] ? DUTY_W'(-span) : span[DUTY_W-1:0];

  always_comb begin
    job_d.cal      = cal;
    job_d.cls_r    = spd_r.cls;
    job_d.cls_l    = spd_l.cls;
    job_d.span_neg = span[SPAN_W-1];
    job_d.mag_r    = MAG_W'(spd_r.mag) * MAG_W'(span_abs);
    job_d.mag_l    = MAG_W'(spd_l.mag) * MAG_W'(span_abs);
  end

  // a line with nothing to send never occupies the job register
  always_comb begin
    job_valid_d = job_valid_q;
    if (in_beat && is_nl && (n_all != '0)) begin
      job_valid_d = 1'b1;
    end else if (job_move) begin
      job_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && is_nl) begin
      job_q <= job_d;
    end
  end

  // ---------------------------------------------------------------------
  // result list and output register
  // ---------------------------------------------------------------------
  sclpwm_result_stage u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid_q),
    .job_i       (job_q),
    .duty_low_i  (duty_low_q),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_wheel_o (out_wheel_o),
    .out_duty_o  (out_duty_o),
    .out_last_o  (out_last_o)
  );

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_job_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && !take |=> job_valid_q && $stable(job_q))
    else $error("pending job lost while result stage busy");

  a_cal_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_CAL) |->
      out_last_o && (out_wheel_o == WHEEL_RIGHT) && (out_duty_o == '0))
    else $error("calibrate beat not a lone zero beat");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !is_nl |=>
      (widx_q == (($past(widx_q) == LAST_IDX) ? LAST_IDX : ($past(widx_q) + IDX_W'(1)))))
    else $error("write index did not advance or clamp");

  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && is_nl |=> (widx_q == '0) && (store_q[POS_R_HI] == CH_ZERO)
      && (store_q[POS_L_LO] == CH_ZERO))
    else $error("newline did not reset the line buffer");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sclpwm_pkg::*;

  localparam int LINE_LEN = 8;

  // one duty write or calibrate request as it should leave the result channel
  typedef struct packed {
    logic              kind;
    logic              wheel;
    logic [DUTY_W-1:0] duty;
    logic              last;
  } duty_write_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [BYTE_W-1:0]    in_rx_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 out_kind_o;
  logic                 out_wheel_o;
  logic [DUTY_W-1:0]    out_duty_o;
  logic                 out_last_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_DUTY_LOW;
  logic [DUTY_W-1:0]    cfg_wdata_i = '0;

  speed_command_line_to_pwm #(
    .LINE_BYTES(LINE_LEN)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_rx_byte_i(in_rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_wheel_o (out_wheel_o),
    .out_duty_o  (out_duty_o),
    .out_last_o  (out_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // bytes still to be sent, and writes the predictor says are on their way
  logic [BYTE_W-1:0] tx_bytes[$];
  duty_write_t       due_writes[$];
  int                mismatches = 0;

  // idling odds in percent, changed by the sequencer between phases
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  // predictor's own copy of the line buffer and duty range
  logic [BYTE_W-1:0] line_buf[LINE_LEN];
  int unsigned       fill_idx;
  logic [DUTY_W-1:0] duty_low_reg;
  logic [DUTY_W-1:0] duty_high_reg;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs somewhere
  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // two-character number: blanks, optional sign, then digits up to the first non-digit
  function automatic int pair_value(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] ch[2];
    int                pos;
    int                val;
    bit                neg;
    ch[0] = a;
    ch[1] = b;
    pos = 0;
    val = 0;
    neg = 1'b0;
    while (pos < 2 && (ch[pos] == CH_SPACE || (ch[pos] >= CH_TAB && ch[pos] <= CH_CR)))
      pos++;
    if (pos < 2 && (ch[pos] == CH_MINUS || ch[pos] == CH_PLUS)) begin
      neg = (ch[pos] == CH_MINUS);
      pos++;
    end
    while (pos < 2 && ch[pos] >= CH_ZERO && ch[pos] <= CH_NINE) begin
      val = val * 10 + int'(ch[pos] - CH_ZERO);
      pos++;
    end
    return neg ? -val : val;
  endfunction

  // feeds one accepted byte to the predictor; a newline queues the writes it causes
  function automatic void take_byte(logic [BYTE_W-1:0] c);
    duty_write_t caused[$];
    duty_write_t w;
    int          speed;
    int          span;
    int          d;
    if (c != CH_NEWLINE) begin
      line_buf[fill_idx] = c;
      // index sticks at the last slot, later bytes overwrite it
      if (fill_idx < LINE_LEN - 1) fill_idx++;
      return;
    end
    line_buf[fill_idx] = '0;
    fill_idx = 0;
    if (line_buf[0] == CH_S && line_buf[4] == CH_P) begin
      w = '{kind: KIND_CAL, wheel: WHEEL_RIGHT, duty: '0, last: 1'b0};
      caused.push_back(w);
    end else begin
      span = int'(duty_high_reg) - int'(duty_low_reg);
      for (int wh = 0; wh < 2; wh++) begin
        speed = wh ? pair_value(line_buf[3], line_buf[4])
                   : pair_value(line_buf[0], line_buf[1]);
        if (speed > 0) begin
          // signed span, quotient truncates toward zero
          d = int'(duty_low_reg) + (speed * span) / 100;
          w = '{kind: KIND_DUTY, wheel: wh[0], duty: d[DUTY_W-1:0], last: 1'b0};
          caused.push_back(w);
        end else if (speed == 0) begin
          // zero speed stops both wheels, right first
          w = '{kind: KIND_DUTY, wheel: WHEEL_RIGHT, duty: '0, last: 1'b0};
          caused.push_back(w);
          w.wheel = WHEEL_LEFT;
          caused.push_back(w);
        end
        // negative speed: nothing for this wheel
      end
    end
    if (caused.size() != 0) caused[caused.size() - 1].last = 1'b1;
    foreach (caused[i]) due_writes.push_back(caused[i]);
    foreach (line_buf[i]) line_buf[i] = CH_ZERO;
  endfunction

  // byte driver: holds valid and payload until the beat is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) take_byte(in_rx_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i   <= 1'b1;
          in_rx_byte_i <= tx_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: every taken beat is checked against the oldest due write
  always @(posedge clk_i) begin
    duty_write_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_writes.size() == 0) begin
          $error("result beat with no write due: kind %0d wheel %0d duty %0d last %0d",
                 out_kind_o, out_wheel_o, out_duty_o, out_last_o);
          mismatches++;
        end else begin
          want = due_writes.pop_front();
          if (out_kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind_o);
            mismatches++;
          end
          if (out_wheel_o !== want.wheel) begin
            $error("wheel: expected %0d, got %0d", want.wheel, out_wheel_o);
            mismatches++;
          end
          if (out_duty_o !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, out_duty_o);
            mismatches++;
          end
          if (out_last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last_o);
            mismatches++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_text(string s);
    foreach (s[i]) tx_bytes.push_back(s[i]);
  endtask

  // any byte except a newline
  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255)); while (b == CH_NEWLINE);
    return b;
  endfunction

  // two characters of a speed field, mostly well formed
  function automatic logic [2*BYTE_W-1:0] speed_text();
    logic [BYTE_W-1:0] d0;
    logic [BYTE_W-1:0] d1;
    d0 = CH_ZERO + BYTE_W'($urandom_range(9));
    d1 = CH_ZERO + BYTE_W'($urandom_range(9));
    case ($urandom_range(7))
      0, 1: return {d0, d1};
      2: return {CH_SPACE, d1};
      3: return {CH_MINUS, d1};
      4: return {CH_PLUS, d1};
      5: return {($urandom_range(1) ? CH_TAB : CH_CR), d1};
      6: return {d0, text_byte()};
      default: return {text_byte(), text_byte()};
    endcase
  endfunction

  // one command line: noise, calibrate or two speeds, maybe trailing junk
  task automatic push_random_line();
    int                  form;
    int                  extra;
    logic [2*BYTE_W-1:0] right_txt;
    logic [2*BYTE_W-1:0] left_txt;
    form = $urandom_range(99);
    if (form < 12) begin
      // raw noise, may hold newlines of its own
      repeat ($urandom_range(12)) tx_bytes.push_back(BYTE_W'($urandom_range(255)));
    end else if (form < 24) begin
      tx_bytes.push_back(CH_S);
      repeat (3) tx_bytes.push_back(text_byte());
      tx_bytes.push_back(CH_P);
    end else begin
      right_txt = speed_text();
      left_txt  = speed_text();
      tx_bytes.push_back(right_txt[15:8]);
      tx_bytes.push_back(right_txt[7:0]);
      tx_bytes.push_back(text_byte());
      tx_bytes.push_back(left_txt[15:8]);
      tx_bytes.push_back(left_txt[7:0]);
    end
    // sometimes run past the last slot so the index clamp gets hit
    extra = ($urandom_range(3) == 0) ? $urandom_range(6) : 0;
    repeat (extra) tx_bytes.push_back(text_byte());
    tx_bytes.push_back(CH_NEWLINE);
  endtask

  // block idle: all bytes sent and all writes seen
  task automatic wait_drained();
    do @(negedge clk_i); while (tx_bytes.size() != 0 || in_valid_i || due_writes.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_duty_range(logic [DUTY_W-1:0] lo, logic [DUTY_W-1:0] hi);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_DUTY_LOW;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_index_i <= REG_DUTY_HIGH;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    duty_low_reg  = lo;
    duty_high_reg = hi;
  endtask

  // sequencer
  initial begin
    foreach (line_buf[i]) line_buf[i] = '0;
    fill_idx      = 0;
    duty_low_reg  = DUTY_LOW_RST;
    duty_high_reg = DUTY_HIGH_RST;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed lines at the reset duty range, no idling
    push_text("\n");          // all-zero buffer: both speeds read as zero
    push_text("s000p\n");     // calibrate request
    push_text("99 99\n");     // top speed on both wheels
    push_text("-5 +1\n");     // negative right is dropped, plus sign on left
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h00);
    push_text(" --\n");       // no digits anywhere, lone minus reads as zero
    wait_drained();

    // random phases, each with its own duty range and idling pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_duty_range('0, '1);
        1: set_duty_range('1, '0);
        default: set_duty_range(DUTY_W'($urandom), DUTY_W'($urandom));
      endcase
      case (p)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 51; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 51; end
        default: begin send_gap_pct = 30; recv_stall_pct = 30; end
      endcase
      repeat (4) begin
        push_random_line();
        // in the stall phase the sender waits out each line's writes
        if (p == 2) wait_drained();
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
